// ===== hdl/prfl_pkg.sv =====
// Shared constants for the page replacement block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package prfl_pkg;

  // Fixed field widths of the interface.
  localparam int ADDR_W  = 9;
  localparam int FAULT_W = 16;
  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

  // Default geometry, handed to the top level parameters.
  localparam int FRAMES_DEF    = 4;
  localparam int PAGES_DEF     = 32;
  localparam int PAGE_SIZE_DEF = 10;
  localparam int AGE_BITS_DEF  = 16;

  // Policy register encoding.
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

endpackage : prfl_pkg

`default_nettype wire

// ===== hdl/prfl_page_calc.sv =====
// Address to page number pipeline: input register, divide by page size and
// wrap modulo page count, each by reciprocal multiplication. Uses prfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prfl_page_calc #(
  parameter int PAGES     = prfl_pkg::PAGES_DEF,
  parameter int PAGE_SIZE = prfl_pkg::PAGE_SIZE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [prfl_pkg::ADDR_W-1:0]  in_address,
  output logic                              pg_valid,
  input  wire logic                         pg_ready,
  output logic [$clog2(PAGES)-1:0]          pg_page
);
  import prfl_pkg::*;

  localparam int PW = $clog2(PAGES);
  // Exact reciprocals for every dividend below 2**ADDR_W.
  localparam int S1 = ADDR_W + $clog2(PAGE_SIZE);
  localparam int M1 = ((2 ** S1) + PAGE_SIZE - 1) / PAGE_SIZE;
  localparam int S2 = ADDR_W + $clog2(PAGES);
  localparam int M2 = ((2 ** S2) + PAGES - 1) / PAGES;

  logic              v0_r, v1_r, v2_r, v3_r;
  logic              rdy0, rdy1, rdy2, rdy3;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] quo_r, quo_nxt;
  logic [ADDR_W-1:0] quo2_r;
  logic [ADDR_W-1:0] wrap_r, wrap_nxt;
  logic [PW-1:0]     page_r, page_nxt;
  logic [31:0]       prod1, prod2, diff;

  // Each stage moves when it is empty or the next one moves.
  assign rdy3     = !v3_r || pg_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  // Quotient by the page size.
  assign prod1   = 32'(addr_r) * 32'(M1);
  assign quo_nxt = prod1[S1 +: ADDR_W];

  // Quotient by the page count, used for the wrap.
  assign prod2    = 32'(quo_r) * 32'(M2);
  assign wrap_nxt = prod2[S2 +: ADDR_W];

  // Remainder by the page count.
  assign diff     = 32'(quo2_r) - (32'(wrap_r) * 32'(PAGES));
  assign page_nxt = diff[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) addr_r <= in_address;
    if (rdy1) quo_r <= quo_nxt;
    if (rdy2) begin
      quo2_r <= quo_r;
      wrap_r <= wrap_nxt;
    end
    if (rdy3) page_r <= page_nxt;
  end

  assign pg_valid = v3_r;
  assign pg_page  = page_r;

endmodule : prfl_page_calc

`default_nettype wire

// ===== hdl/prfl_frame_table.sv =====
// Frame table: parallel lookup, victim selection, age and fault update,
// and the result register. Uses prfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prfl_frame_table #(
  parameter int FRAMES   = prfl_pkg::FRAMES_DEF,
  parameter int PAGES    = prfl_pkg::PAGES_DEF,
  parameter int AGE_BITS = prfl_pkg::AGE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          policy,
  input  wire logic                          pg_valid,
  output logic                               pg_ready,
  input  wire logic [$clog2(PAGES)-1:0]      pg_page,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit,
  output logic [$clog2(FRAMES)-1:0]          out_frame_index,
  output logic [$clog2(PAGES)-1:0]           out_page_number,
  output logic                               out_evicted_valid,
  output logic [$clog2(PAGES)-1:0]           out_evicted_page,
  output logic [prfl_pkg::FAULT_W-1:0]       out_fault_total
);
  import prfl_pkg::*;

  localparam int PW = $clog2(PAGES);
  localparam int FW = $clog2(FRAMES);
  localparam int NP = 1 << FW;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  logic [PW-1:0]       fpage_r [FRAMES];
  logic [PW-1:0]       fpage_nxt [FRAMES];
  logic [FRAMES-1:0]   fvalid_r, fvalid_nxt;
  logic [AGE_BITS-1:0] fage_r [FRAMES];
  logic [AGE_BITS-1:0] fage_nxt [FRAMES];
  logic [FAULT_W-1:0]  fault_r, fault_nxt;

  logic                out_valid_r;
  logic                hit_r, ev_valid_r;
  logic [FW-1:0]       slot_r;
  logic [PW-1:0]       page_r, ev_page_r;

  logic [FRAMES-1:0]   hit_vec;
  logic                hit, any_empty, evict, take, do_age;
  logic [FW-1:0]       hit_idx, empty_idx, slot;
  logic [PW-1:0]       ev_page;

  // Victim search: registered-free tournament tree, lower index wins ties.
  logic [AGE_BITS-1:0] node_age [2*NP-1];
  logic [FW-1:0]       node_idx [2*NP-1];

  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < FRAMES) begin : g_real
      assign node_age[NP-1+i] = fage_r[i];
    end else begin : g_pad
      assign node_age[NP-1+i] = '0;
    end
    assign node_idx[NP-1+i] = FW'(i);
  end

  for (genvar n = 0; n < NP - 1; n++) begin : g_node
    assign node_age[n] = (node_age[2*n+2] > node_age[2*n+1]) ?
                         node_age[2*n+2] : node_age[2*n+1];
    assign node_idx[n] = (node_age[2*n+2] > node_age[2*n+1]) ?
                         node_idx[2*n+2] : node_idx[2*n+1];
  end

  assign pg_ready = !out_valid_r || out_ready;
  assign take     = pg_valid && pg_ready;

  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      hit_vec[k] = fvalid_r[k] && (fpage_r[k] == pg_page);
      if (hit_vec[k]) hit_idx = FW'(k);
      if (!fvalid_r[k]) empty_idx = FW'(k);
    end
    hit       = |hit_vec;
    any_empty = !(&fvalid_r);
    evict     = !hit && !any_empty;
    priority if (hit)       slot = hit_idx;
    else if (any_empty)     slot = empty_idx;
    else                    slot = node_idx[0];
    ev_page   = evict ? fpage_r[slot] : '0;
    do_age    = !hit || (policy == POLICY_LRU);
  end

  always_comb begin
    fvalid_nxt = fvalid_r;
    fault_nxt  = fault_r;
    for (int k = 0; k < FRAMES; k++) begin
      fpage_nxt[k] = fpage_r[k];
      fage_nxt[k]  = fage_r[k];
      if (take && !hit && (slot == FW'(k))) begin
        fpage_nxt[k]  = pg_page;
        fvalid_nxt[k] = 1'b1;
      end
      if (take && do_age) begin
        if (slot == FW'(k)) begin
          fage_nxt[k] = '0;
        end else if (fvalid_r[k] && (fage_r[k] != AGE_MAX)) begin
          fage_nxt[k] = fage_r[k] + 1'b1;
        end
      end
    end
    if (take && !hit && (fault_r != FAULT_MAX)) begin
      fault_nxt = fault_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r    <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < FRAMES; k++) begin
        fage_r[k] <= '0;
      end
    end else begin
      fvalid_r <= fvalid_nxt;
      fault_r  <= fault_nxt;
      fage_r   <= fage_nxt;
      if (pg_ready) out_valid_r <= pg_valid;
    end
  end

  always_ff @(posedge clk) begin
    fpage_r <= fpage_nxt;
    if (take) begin
      hit_r      <= hit;
      slot_r     <= slot;
      page_r     <= pg_page;
      ev_valid_r <= evict;
      ev_page_r  <= ev_page;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = hit_r;
  assign out_frame_index   = slot_r;
  assign out_page_number   = page_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_page  = ev_page_r;
  // The fault register already holds the count including the item shown.
  assign out_fault_total   = fault_r;

endmodule : prfl_frame_table

`default_nettype wire

// ===== hdl/page_replacement_fifo_lru.sv =====
// Throughput: one word per cycle unless a result word is stalled at out_ready;
// the frame table looks up and updates all frames in the same cycle, so
// consecutive accesses never wait on each other.
// Reset (rst_n low, synchronous): all frames empty, ages and fault count
// zero, policy first in first out, no word in flight.
// Depends on prfl_pkg, prfl_page_calc and prfl_frame_table.
`timescale 1ns / 1ps
`default_nettype none

module page_replacement_fifo_lru #(
  parameter int FRAMES    = prfl_pkg::FRAMES_DEF,
  parameter int PAGES     = prfl_pkg::PAGES_DEF,
  parameter int PAGE_SIZE = prfl_pkg::PAGE_SIZE_DEF,
  parameter int AGE_BITS  = prfl_pkg::AGE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Policy register write port.
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_data,
  // Address words in.
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [prfl_pkg::ADDR_W-1:0]  in_address,
  // Result words out.
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_hit,
  output logic [$clog2(FRAMES)-1:0]         out_frame_index,
  output logic [$clog2(PAGES)-1:0]          out_page_number,
  output logic                              out_evicted_valid,
  output logic [$clog2(PAGES)-1:0]          out_evicted_page,
  output logic [prfl_pkg::FAULT_W-1:0]      out_fault_total
);
  import prfl_pkg::*;

  localparam int PW = $clog2(PAGES);

  logic          policy_r;
  logic          pg_valid, pg_ready;
  logic [PW-1:0] pg_page;

  // The policy register is always ready. A change of policy takes effect on
  // the next access that reaches the frame table; the ages are shared by
  // both policies and are left as they are.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_FIFO;
    end else if (cfg_valid) begin
      policy_r <= cfg_data;
    end
  end

  // Four register stages turn the address into a page number. The divide by
  // the page size and the wrap modulo the page count are both done as
  // multiplications by exact reciprocals.
  prfl_page_calc #(
    .PAGES     (PAGES),
    .PAGE_SIZE (PAGE_SIZE)
  ) u_page_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_address (in_address),
    .pg_valid   (pg_valid),
    .pg_ready   (pg_ready),
    .pg_page    (pg_page)
  );

  // The frame table compares the page against every frame at once, picks
  // the lowest empty frame or the oldest frame as victim, updates ages and
  // the saturating fault count, and holds the result word until it is taken.
  prfl_frame_table #(
    .FRAMES   (FRAMES),
    .PAGES    (PAGES),
    .AGE_BITS (AGE_BITS)
  ) u_frame_table (
    .clk               (clk),
    .rst_n             (rst_n),
    .policy            (policy_r),
    .pg_valid          (pg_valid),
    .pg_ready          (pg_ready),
    .pg_page           (pg_page),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_page_number   (out_page_number),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

endmodule : page_replacement_fifo_lru

`default_nettype wire

// ===== hdl/prfl_checker.sv =====
// Port-level checks on the page replacement block, bound to its top level.
// Depends on page_replacement_fifo_lru for the bind target.
`timescale 1ns / 1ps
`default_nettype none

module prfl_checker #(
  parameter int PW = 5
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_hit,
  input wire logic                          out_evicted_valid,
  input wire logic [PW-1:0]                 out_evicted_page,
  input wire logic [prfl_pkg::FAULT_W-1:0]  out_fault_total
);
  import prfl_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_fault_total)
                                   && $stable(out_hit)))
    else $error("result word changed while stalled");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_evicted_valid)
    else $error("eviction reported on a hit");

  // No eviction means the evicted page reads as zero.
  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted_valid) |-> (out_evicted_page == '0))
    else $error("evicted page not zero without eviction");

  // The fault count never decreases from one result word to the next.
  a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=>
      (!out_valid || (out_fault_total >= $past(out_fault_total))))
    else $error("fault count went down");

endmodule : prfl_checker

bind page_replacement_fifo_lru prfl_checker #(
  .PW ($clog2(PAGES))
) u_prfl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_hit           (out_hit),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_page  (out_evicted_page),
  .out_fault_total   (out_fault_total)
);

`default_nettype wire
